// File: hw/rtl/far_pkg.sv
// ---------------------------------------------------------------------------
// far_pkg: shared types and constants for the frame average rotate core
// Holds register indexes and the front-to-back work descriptor.
// ---------------------------------------------------------------------------
`default_nettype none
package far_pkg;
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegImageWidth = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegFramesToAverage = 2'd2;
  localparam int DimBits = 11;
  localparam int CountBits = 8;
  localparam int AddrBits = 20;
  localparam int PixBits = 16;
  // largest image, sets the store depth and the address width
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [PixBits-1:0]   pixel;
    logic [AddrBits-1:0]  addr;
    logic [CountBits-1:0] count;
    logic                 complete;
    logic                 last;
  } far_work_t;
endpackage
`default_nettype wire

// File: hw/rtl/frame_average_rotate_core.sv
// ---------------------------------------------------------------------------
// frame_average_rotate_core: running frame average with rotated addressing
// Raw pixels in raster order come in on s_axis; each result leaves on
// m_axis with the updated average and its rotated address in tdata, the
// complete flag on tuser and tlast on the last pixel of a frame.
// Registers are written on the cfg channel (0 width, 1 height, 2 frames to
// average); the user must write them only while idle, the block does not enforce it.
// A front stage tracks column, row and frame count and computes the
// address; a two-entry queue feeds the back, which reads the store, divides
// one quotient bit per cycle and writes back. The back takes a pixel, reads
// the store, divides and outputs; it takes no new pixel until that result
// has left on m_axis. The front and queue keep accepting while a result
// waits. Reset clears position and count and restores width 1024, height
// 1024, one frame; the store needs no clearing. A stalled m_axis holds its
// result and fills the queue, then s_axis stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module frame_average_rotate_core
  import far_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // raw_pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // averaged_pixel, rotated_address
  output logic             m_axis_tuser,   // average_complete
  output logic             m_axis_tlast,   // frame_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int DepthBits = $clog2(MaxWidth) + $clog2(MaxHeight);

  logic [DimBits-1:0] image_width, image_height;
  logic [CountBits-1:0] frames_to_average;
  logic f_valid, f_ready, q_valid, q_ready;
  far_work_t f_work, q_work;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= DimBits'(1024);
      image_height <= DimBits'(1024);
      frames_to_average <= CountBits'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegImageWidth: image_width <= cfg_data[DimBits-1:0];
        RegImageHeight: image_height <= cfg_data[DimBits-1:0];
        RegFramesToAverage: frames_to_average <= cfg_data[CountBits-1:0];
        default: ;
      endcase
    end
  end

  far_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_pixel(s_axis_tdata), .image_width, .image_height, .frames_to_average,
    .wk_valid(f_valid), .wk_ready(f_ready), .wk(f_work));

  far_queue u_queue (
    .clk, .rst, .s_valid(f_valid), .s_ready(f_ready), .s_data(f_work),
    .m_valid(q_valid), .m_ready(q_ready), .m_data(q_work));

  far_back #(.DEPTH_BITS(DepthBits)) u_back (
    .clk, .rst, .wk_valid(q_valid), .wk_ready(q_ready), .wk(q_work),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast));
endmodule
`default_nettype wire

// File: hw/rtl/far_front.sv
// ---------------------------------------------------------------------------
// far_front: position tracking and address generation
// Tracks column, row and frame count, emits one work descriptor per pixel.
// ---------------------------------------------------------------------------
`default_nettype none
module far_front
  import far_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PixBits-1:0]   in_pixel,
  input  wire logic [DimBits-1:0]   image_width,
  input  wire logic [DimBits-1:0]   image_height,
  input  wire logic [CountBits-1:0] frames_to_average,
  output logic                      wk_valid,
  input  wire logic                 wk_ready,
  output far_work_t                 wk
);
  localparam int ColBits = $clog2(MaxWidth);
  localparam int RowBits = $clog2(MaxHeight);
  localparam int DepthBits = ColBits + RowBits;
  localparam logic [DimBits+1:0] MaxW = (DimBits+2)'(MaxWidth);
  localparam logic [DimBits+1:0] MaxH = (DimBits+2)'(MaxHeight);
  localparam logic [PixBits-1:0] PixMask = PixBits'((32'd1 << PIXEL_BITS) - 1);

  logic [DimBits+1:0] col, row, col_next, row_next;
  logic [CountBits-1:0] frames;
  logic [DimBits+1:0] w, h, cc, rr;
  logic [CountBits-1:0] total;
  logic [2*DimBits+3:0] prod;
  logic [DepthBits-1:0] addr;
  logic last, complete, take;

  always_comb begin
    w = {2'b0, image_width};
    if (w == '0) w = (DimBits+2)'(1);
    else if (w > MaxW) w = MaxW;
    h = {2'b0, image_height};
    if (h == '0) h = (DimBits+2)'(1);
    else if (h > MaxH) h = MaxH;
    total = (frames_to_average == '0) ? CountBits'(1) : frames_to_average;
    cc = col;
    rr = row;
    if (col >= w || row >= h) begin
      cc = '0;
      rr = '0;
    end
    prod = (2*DimBits+4)'(w - 1 - cc) * (2*DimBits+4)'(h) + (2*DimBits+4)'(rr);
    addr = DepthBits'(prod);
    last = (cc == w - 1) && (rr == h - 1);
    complete = ({1'b0, frames} + 1) >= {1'b0, total};
    col_next = cc + 1'b1;
    row_next = rr;
    if (cc + 1 >= w) begin
      col_next = '0;
      row_next = (rr + 1 < h) ? rr + 1'b1 : '0;
    end
  end

  assign in_ready = !wk_valid || wk_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      frames <= '0;
      wk_valid <= 1'b0;
    end else begin
      if (wk_valid && wk_ready) wk_valid <= 1'b0;
      if (take) begin
        wk_valid <= 1'b1;
        col <= col_next;
        row <= row_next;
        if (last) frames <= complete ? '0 : frames + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wk.pixel <= in_pixel & PixMask;
      wk.addr <= AddrBits'(addr);
      wk.count <= frames;
      wk.complete <= complete;
      wk.last <= last;
    end
  end

  a_frames_range: assert property (@(posedge clk) disable iff (rst)
    frames < 8'd255)
    else $error("frame count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    wk_valid && !wk_ready |=> wk_valid && $stable(wk))
    else $error("work lost under stall");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    wk_valid |-> $past(wk_valid) || $past(take))
    else $error("unexpected work");
endmodule
`default_nettype wire

// File: hw/rtl/far_queue.sv
// ---------------------------------------------------------------------------
// far_queue: short work queue between front and back
// Two-entry fifo so either side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none
module far_queue
  import far_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_valid,
  output logic           s_ready,
  input  wire far_work_t s_data,
  output logic           m_valid,
  input  wire logic      m_ready,
  output far_work_t      m_data
);
  far_work_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign s_ready = cnt != 2'd2;
  assign m_valid = cnt != 2'd0;
  assign m_data = mem[rp];
  assign push = s_valid && s_ready;
  assign pop = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= s_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
endmodule
`default_nettype wire

// File: hw/rtl/far_back.sv
// ---------------------------------------------------------------------------
// far_back: store read, running average and write back
// Reads the old average, divides bit-serially, writes and emits.
// ---------------------------------------------------------------------------
`default_nettype none
module far_back
  import far_pkg::*;
#(
  parameter int DEPTH_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wk_valid,
  output logic            wk_ready,
  input  wire far_work_t  wk,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [39:0]     out_data,
  output logic            out_user,
  output logic            out_last
);
  localparam int NumBits = PixBits + CountBits + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [PixBits-1:0] store [2**DEPTH_BITS];
  logic [PixBits-1:0] old;
  far_work_t cur;
  logic [NumBits-1:0] num, quo;
  logic [CountBits:0] rem, den;
  logic [4:0] step;
  logic [CountBits+1:0] trial;

  assign wk_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign trial = {rem, num[NumBits-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (state == S_IDLE && wk_valid) old <= store[DEPTH_BITS'(wk.addr)];
    if (state == S_DIV && step == 5'(NumBits)) begin
      store[DEPTH_BITS'(cur.addr)] <= quo[PixBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (wk_valid) begin
          cur <= wk;
          state <= S_READ;
        end
        S_READ: begin
          // numerator old*count+pixel, one quotient bit a cycle
          // first frame of a run never looks at the stored value
          if (cur.count == '0) begin
            num <= NumBits'(cur.pixel);
          end else begin
            num <= NumBits'(old) * NumBits'(cur.count) + NumBits'(cur.pixel);
          end
          den <= {1'b0, cur.count} + 1'b1;
          rem <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == 5'(NumBits)) begin
            state <= S_OUT;
          end else begin
            num <= num << 1;
            if (!trial[CountBits+1]) begin
              rem <= trial[CountBits:0];
              quo <= {quo[NumBits-2:0], 1'b1};
            end else begin
              rem <= {rem[CountBits-1:0], num[NumBits-1]};
              quo <= {quo[NumBits-2:0], 1'b0};
            end
            step <= step + 1'b1;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data = {4'b0, cur.addr, quo[PixBits-1:0]};
  assign out_user = cur.complete;
  assign out_last = cur.last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_take: assert property (@(posedge clk) disable iff (rst)
    wk_valid && wk_ready |=> state == S_READ) else $error("missed work");
endmodule
`default_nettype wire
